[design/assert_macros.svh]
// Assertion macros shared by the pixel format converter RTL.
// Included by bare file name; no other dependencies.
// In synthesis builds every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clk edge outside reset.
`define RPFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true at a rising clk edge outside reset.
`define RPFC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RPFC_ASSERT(lbl, prop, msg)
`define RPFC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[design/rpfc_pkg.sv]
// Package for the RGBA pixel format converter: format codes, register
// indexes, byte counts and small helper functions. No dependencies.
`timescale 1ns / 1ps

package rpfc_pkg;

    localparam int PixW = 8;
    localparam int CntW = 3;
    localparam int FmtW = 4;
    localparam int RegIdxW = 2;
    localparam int ApbAddrW = 4;
    localparam int ApbDataW = 32;

    localparam logic [PixW-1:0] FullAlpha = 8'hff;
    localparam logic [PixW-1:0] PadByte = 8'hff;
    localparam logic [CntW-1:0] Count3 = 3'd3;
    localparam logic [CntW-1:0] Count4 = 3'd4;

    typedef enum logic [FmtW-1:0] {
        FMT_RGB  = 4'd0,
        FMT_BGR  = 4'd1,
        FMT_RGBA = 4'd2,
        FMT_ARGB = 4'd3,
        FMT_BGRA = 4'd4,
        FMT_ABGR = 4'd5,
        FMT_XRGB = 4'd6,
        FMT_RGBX = 4'd7,
        FMT_XBGR = 4'd8,
        FMT_BGRX = 4'd9
    } fmt_t;

    typedef enum logic [RegIdxW-1:0] {
        REG_OUT_FORMAT = 2'd0,
        REG_BG_RED     = 2'd1,
        REG_BG_GREEN   = 2'd2,
        REG_BG_BLUE    = 2'd3
    } reg_idx_t;

    localparam logic [FmtW-1:0] FmtReset = FMT_RGBA;

    // Codes above BGRX behave as RGBA.
    function automatic fmt_t fmt_effective(input logic [FmtW-1:0] code);
        fmt_t f;
        if (code > FMT_BGRX) begin
            f = FMT_RGBA;
        end else begin
            f = fmt_t'(code);
        end
        return f;
    endfunction

    function automatic logic fmt_has_alpha(input fmt_t f);
        return (f == FMT_RGBA) || (f == FMT_ARGB) || (f == FMT_BGRA) || (f == FMT_ABGR);
    endfunction

endpackage

[design/rgba_pixel_format_converter.sv]
// Top level of the RGBA8888 pixel format converter: APB register file,
// two-register pixel path, blend units (rpfc_blend) and byte packing. Uses rpfc_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Handshake                  Payload
// -------   ------------------------   ---------------------------------------------
// input     in_valid / in_stall        in_red, in_green, in_blue, in_alpha, in_last
// output    out_valid / out_stall      out_byte0..3, byte_count, out_last, image_opaque
// config    APB psel/penable/pwrite    paddr, pwdata, prdata, pready (always high)
//
// Throughput is one pixel per clock while out_stall is low. A pixel enters the
// input register, then passes the blend multiplier into the result register.
// The result register and the input register form a two-deep pipeline, so a new
// pixel is taken while a finished one waits on out_stall.
// in_stall rises only when both registers are full and the output is stalled.
// Reset clears both valid flags, loads the reset register values and sets the
// opaque-run flag; no clearing pass is needed.

module rgba_pixel_format_converter (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rpfc_pkg::ApbAddrW-1:0]     paddr,
    input  logic [rpfc_pkg::ApbDataW-1:0]     pwdata,
    output logic [rpfc_pkg::ApbDataW-1:0]     prdata,
    output logic                              pready,
    // Pixel input
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rpfc_pkg::PixW-1:0]         in_red,
    input  logic [rpfc_pkg::PixW-1:0]         in_green,
    input  logic [rpfc_pkg::PixW-1:0]         in_blue,
    input  logic [rpfc_pkg::PixW-1:0]         in_alpha,
    input  logic                              in_last,
    // Packed pixel output
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rpfc_pkg::PixW-1:0]         out_byte0,
    output logic [rpfc_pkg::PixW-1:0]         out_byte1,
    output logic [rpfc_pkg::PixW-1:0]         out_byte2,
    output logic [rpfc_pkg::PixW-1:0]         out_byte3,
    output logic [rpfc_pkg::CntW-1:0]         byte_count,
    output logic                              out_last,
    output logic                              image_opaque
);

    // ------------------------------------------------------------------
    // Configuration registers. The index is the word address; the low
    // two address bits select bytes within a word and are ignored.
    // ------------------------------------------------------------------
    logic [rpfc_pkg::FmtW-1:0]    out_format_reg;
    logic [rpfc_pkg::PixW-1:0]    bg_red_reg;
    logic [rpfc_pkg::PixW-1:0]    bg_green_reg;
    logic [rpfc_pkg::PixW-1:0]    bg_blue_reg;
    logic                         cfg_write;
    rpfc_pkg::reg_idx_t           cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = rpfc_pkg::reg_idx_t'(paddr[rpfc_pkg::ApbAddrW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_format_reg <= rpfc_pkg::FmtReset;
            bg_red_reg     <= '0;
            bg_green_reg   <= '0;
            bg_blue_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                rpfc_pkg::REG_OUT_FORMAT: out_format_reg <= pwdata[rpfc_pkg::FmtW-1:0];
                rpfc_pkg::REG_BG_RED:     bg_red_reg     <= pwdata[rpfc_pkg::PixW-1:0];
                rpfc_pkg::REG_BG_GREEN:   bg_green_reg   <= pwdata[rpfc_pkg::PixW-1:0];
                rpfc_pkg::REG_BG_BLUE:    bg_blue_reg    <= pwdata[rpfc_pkg::PixW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            rpfc_pkg::REG_OUT_FORMAT: prdata[rpfc_pkg::FmtW-1:0] = out_format_reg;
            rpfc_pkg::REG_BG_RED:     prdata[rpfc_pkg::PixW-1:0] = bg_red_reg;
            rpfc_pkg::REG_BG_GREEN:   prdata[rpfc_pkg::PixW-1:0] = bg_green_reg;
            rpfc_pkg::REG_BG_BLUE:    prdata[rpfc_pkg::PixW-1:0] = bg_blue_reg;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control. The input register advances into the result
    // register whenever the result register is empty or being drained.
    // ------------------------------------------------------------------
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         s1_advance;
    logic                         in_take;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_take    = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Input register: the source pixel as accepted.
    // ------------------------------------------------------------------
    logic [rpfc_pkg::PixW-1:0]    s1_red_reg;
    logic [rpfc_pkg::PixW-1:0]    s1_green_reg;
    logic [rpfc_pkg::PixW-1:0]    s1_blue_reg;
    logic [rpfc_pkg::PixW-1:0]    s1_alpha_reg;
    logic                         s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_red_reg   <= in_red;
            s1_green_reg <= in_green;
            s1_blue_reg  <= in_blue;
            s1_alpha_reg <= in_alpha;
            s1_last_reg  <= in_last;
        end
    end

    // ------------------------------------------------------------------
    // Blend and pack. Configuration must change only while the block is idle;
    // the block does not enforce it. If kept, this reads the arrival-time value.
    // ------------------------------------------------------------------
    rpfc_pkg::fmt_t               fmt;
    logic                         has_alpha;
    logic [rpfc_pkg::PixW-1:0]    mix_red;
    logic [rpfc_pkg::PixW-1:0]    mix_green;
    logic [rpfc_pkg::PixW-1:0]    mix_blue;
    logic [rpfc_pkg::PixW-1:0]    ch_red;
    logic [rpfc_pkg::PixW-1:0]    ch_green;
    logic [rpfc_pkg::PixW-1:0]    ch_blue;
    logic [rpfc_pkg::PixW-1:0]    ch_alpha;
    logic [rpfc_pkg::PixW-1:0]    byte0_next;
    logic [rpfc_pkg::PixW-1:0]    byte1_next;
    logic [rpfc_pkg::PixW-1:0]    byte2_next;
    logic [rpfc_pkg::PixW-1:0]    byte3_next;
    logic [rpfc_pkg::CntW-1:0]    count_next;
    logic                         opaque_run;
    logic                         opaque_next;
    logic                         all_alpha_full_reg;
    logic                         all_alpha_full_next;

    assign fmt       = rpfc_pkg::fmt_effective(out_format_reg);
    assign has_alpha = rpfc_pkg::fmt_has_alpha(fmt);

    rpfc_blend u_blend_red (
        .color (s1_red_reg),
        .bg    (bg_red_reg),
        .alpha (s1_alpha_reg),
        .mixed (mix_red)
    );

    rpfc_blend u_blend_green (
        .color (s1_green_reg),
        .bg    (bg_green_reg),
        .alpha (s1_alpha_reg),
        .mixed (mix_green)
    );

    rpfc_blend u_blend_blue (
        .color (s1_blue_reg),
        .bg    (bg_blue_reg),
        .alpha (s1_alpha_reg),
        .mixed (mix_blue)
    );

    // Alpha formats pass colors through; the rest use the blended values.
    assign ch_red   = has_alpha ? s1_red_reg   : mix_red;
    assign ch_green = has_alpha ? s1_green_reg : mix_green;
    assign ch_blue  = has_alpha ? s1_blue_reg  : mix_blue;
    assign ch_alpha = s1_alpha_reg;

    always_comb
    begin
        byte0_next = ch_red;
        byte1_next = ch_green;
        byte2_next = ch_blue;
        byte3_next = ch_alpha;
        count_next = rpfc_pkg::Count4;
        unique case (fmt)
            rpfc_pkg::FMT_RGB:
            begin
                byte3_next = '0;
                count_next = rpfc_pkg::Count3;
            end
            rpfc_pkg::FMT_BGR:
            begin
                byte0_next = ch_blue;
                byte2_next = ch_red;
                byte3_next = '0;
                count_next = rpfc_pkg::Count3;
            end
            rpfc_pkg::FMT_ARGB:
            begin
                byte0_next = ch_alpha;
                byte1_next = ch_red;
                byte2_next = ch_green;
                byte3_next = ch_blue;
            end
            rpfc_pkg::FMT_BGRA:
            begin
                byte0_next = ch_blue;
                byte2_next = ch_red;
            end
            rpfc_pkg::FMT_ABGR:
            begin
                byte0_next = ch_alpha;
                byte1_next = ch_blue;
                byte2_next = ch_green;
                byte3_next = ch_red;
            end
            rpfc_pkg::FMT_XRGB:
            begin
                byte0_next = rpfc_pkg::PadByte;
                byte1_next = ch_red;
                byte2_next = ch_green;
                byte3_next = ch_blue;
            end
            rpfc_pkg::FMT_RGBX:
            begin
                byte3_next = rpfc_pkg::PadByte;
            end
            rpfc_pkg::FMT_XBGR:
            begin
                byte0_next = rpfc_pkg::PadByte;
                byte1_next = ch_blue;
                byte2_next = ch_green;
                byte3_next = ch_red;
            end
            rpfc_pkg::FMT_BGRX:
            begin
                byte0_next = ch_blue;
                byte2_next = ch_red;
                byte3_next = rpfc_pkg::PadByte;
            end
            default: ;  // RGBA keeps the defaults above.
        endcase
    end

    // The opaque run covers every pixel of the image up to and including
    // this one; it restarts after the last pixel.
    assign opaque_run          = all_alpha_full_reg && (s1_alpha_reg == rpfc_pkg::FullAlpha);
    assign opaque_next         = s1_last_reg && (!has_alpha || opaque_run);
    assign all_alpha_full_next = s1_last_reg ? 1'b1 : opaque_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_alpha_full_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            all_alpha_full_reg <= all_alpha_full_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic [rpfc_pkg::PixW-1:0]    out_byte0_reg;
    logic [rpfc_pkg::PixW-1:0]    out_byte1_reg;
    logic [rpfc_pkg::PixW-1:0]    out_byte2_reg;
    logic [rpfc_pkg::PixW-1:0]    out_byte3_reg;
    logic [rpfc_pkg::CntW-1:0]    byte_count_reg;
    logic                         out_last_reg;
    logic                         image_opaque_reg;

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_byte0_reg    <= byte0_next;
            out_byte1_reg    <= byte1_next;
            out_byte2_reg    <= byte2_next;
            out_byte3_reg    <= byte3_next;
            byte_count_reg   <= count_next;
            out_last_reg     <= s1_last_reg;
            image_opaque_reg <= opaque_next;
        end
    end

    assign out_byte0    = out_byte0_reg;
    assign out_byte1    = out_byte1_reg;
    assign out_byte2    = out_byte2_reg;
    assign out_byte3    = out_byte3_reg;
    assign byte_count   = byte_count_reg;
    assign out_last     = out_last_reg;
    assign image_opaque = image_opaque_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RPFC_ASSERT(a_stall_only_when_full, in_stall |-> (s1_valid_reg && out_valid_reg), "in_stall while pipeline has room")
    `RPFC_ASSERT(a_count_legal, out_valid_reg |-> (byte_count_reg == rpfc_pkg::Count3 || byte_count_reg == rpfc_pkg::Count4), "byte_count not 3 or 4")
    `RPFC_ASSERT_NEVER(a_opaque_without_last, out_valid_reg && image_opaque_reg && !out_last_reg, "image_opaque set off the last pixel")
    `RPFC_ASSERT(a_short_pixel_zero, (out_valid_reg && byte_count_reg == rpfc_pkg::Count3) |-> (out_byte3_reg == '0), "byte3 nonzero on a three-byte pixel")
    `RPFC_ASSERT(a_opaque_restart, (s1_advance && s1_last_reg) |=> all_alpha_full_reg, "opaque run not restarted after last pixel")

endmodule

[design/rpfc_blend.sv]
// One color channel blended over the background: floor((c*a + bg*(255-a))/255).
// Uses rpfc_pkg for widths.
`timescale 1ns / 1ps

module rpfc_blend (
    input  logic [rpfc_pkg::PixW-1:0] color,
    input  logic [rpfc_pkg::PixW-1:0] bg,
    input  logic [rpfc_pkg::PixW-1:0] alpha,
    output logic [rpfc_pkg::PixW-1:0] mixed
);

    // c*a + bg*(255-a) is rewritten as a*(c-bg) + 255*bg, one 9x9 signed product.
    logic signed [8:0]  diff;
    logic signed [8:0]  alpha_s;
    logic signed [17:0] prod;
    logic [15:0]        base;
    logic signed [17:0] total;
    logic [15:0]        mix;
    logic [16:0]        quot;

    assign diff    = signed'({1'b0, color}) - signed'({1'b0, bg});
    assign alpha_s = signed'({1'b0, alpha});
    assign prod    = diff * alpha_s;
    assign base    = {bg, 8'h00} - {8'h00, bg};
    assign total   = prod + signed'({2'b00, base});
    // The blend is a convex mix, so the total stays within 0..65025.
    assign mix     = total[15:0];
    // Division by 255 for values below 65535: (x + 1 + (x >> 8)) >> 8.
    assign quot    = {1'b0, mix} + 17'd1 + {9'd0, mix[15:8]};
    assign mixed   = quot[15:8];

endmodule

[verif/rgba_pixel_format_converter_tb.sv]
// Self-checking testbench for rgba_pixel_format_converter: directed and random pixel
// streams with a local conversion predictor and scoreboard. Needs rpfc_pkg and the RTL.
// Stand-alone: no files, plusargs or external code.
`timescale 1ns / 1ps

module rgba_pixel_format_converter_tb;

    import rpfc_pkg::*;

    // Timing of the bench. The block has an input and a result register, so drain
    // waits on after the last result to see any stray output beat.
    localparam int ClkHalf = 4;
    localparam int ResetCycles = 12;
    localparam int LatencyCycles = 2;
    localparam int IdleLimit = 4000;
    localparam int HoldCycles = 200;
    localparam int RandomItems = 1600;
    localparam int PressureItems = 40;

    // Highest code the format register can hold; codes above BGRX have no
    // format of their own and must behave as RGBA.
    localparam logic [FmtW-1:0] FmtCodeTop = 4'hf;

    // One packed output pixel, field for field as the block presents it.
    typedef struct packed {
        logic [PixW-1:0] b0;
        logic [PixW-1:0] b1;
        logic [PixW-1:0] b2;
        logic [PixW-1:0] b3;
        logic [CntW-1:0] cnt;
        logic            last;
        logic            opaque;
    } packed_pixel_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;
    logic                in_valid;
    logic                in_stall;
    logic [PixW-1:0]     in_red;
    logic [PixW-1:0]     in_green;
    logic [PixW-1:0]     in_blue;
    logic [PixW-1:0]     in_alpha;
    logic                in_last;
    logic                out_valid;
    logic                out_stall;
    logic [PixW-1:0]     out_byte0;
    logic [PixW-1:0]     out_byte1;
    logic [PixW-1:0]     out_byte2;
    logic [PixW-1:0]     out_byte3;
    logic [CntW-1:0]     byte_count;
    logic                out_last;
    logic                image_opaque;

    // Local copy of the register file and of the opaque-run flag, kept in step
    // with the block: registers change only on APB writes, the flag on every
    // accepted input beat.
    logic [FmtW-1:0]     fmt_reg = FmtReset;
    logic [PixW-1:0]     bg_red_reg = '0;
    logic [PixW-1:0]     bg_green_reg = '0;
    logic [PixW-1:0]     bg_blue_reg = '0;
    logic                alpha_run_full = 1'b1;

    // Converted pixels waiting for their output beat, oldest first.
    packed_pixel_t       pending_pixels[$];

    // Idle rates in percent for each side, and the length of a forced hold-off
    // on the output side, counted down by the receiver process.
    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 0;
    int                  hold_left = 0;

    // Content mode of the image being sent: solid images keep alpha mostly at full,
    // so that image_opaque can come back high for alpha formats.
    logic                solid_image = 1'b1;

    int                  mismatches = 0;
    int                  pixels_in = 0;
    int                  pixels_out = 0;
    int                  image_ends = 0;
    int                  opaque_ends = 0;
    int                  held_off_cycles = 0;
    int                  idle_cycles = 0;
    logic [15:0]         codes_seen = '0;

    always #(ClkHalf) clk = ~clk;

    rgba_pixel_format_converter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .in_alpha     (in_alpha),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte0    (out_byte0),
        .out_byte1    (out_byte1),
        .out_byte2    (out_byte2),
        .out_byte3    (out_byte3),
        .byte_count   (byte_count),
        .out_last     (out_last),
        .image_opaque (image_opaque)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Composite one channel over the background: floor((c*a + bg*(255-a))/255).
    function automatic logic [PixW-1:0] blend_over_bg(input logic [PixW-1:0] c,
                                                      input logic [PixW-1:0] bg,
                                                      input logic [PixW-1:0] a);
        int unsigned full;
        int unsigned sum;
        full = 32'(FullAlpha);
        sum = int'(c) * int'(a) + int'(bg) * (full - int'(a));
        return PixW'(sum / full);
    endfunction

    // Expected output beat for one input pixel under the current registers and
    // the opaque run so far.
    function automatic packed_pixel_t convert_pixel(input logic [PixW-1:0] r,
                                                    input logic [PixW-1:0] g,
                                                    input logic [PixW-1:0] b,
                                                    input logic [PixW-1:0] a,
                                                    input logic last);
        fmt_t          f;
        logic          keeps_alpha;
        packed_pixel_t p;
        if (fmt_reg > FMT_BGRX)
        begin
            f = FMT_RGBA;
        end
        else
        begin
            f = fmt_t'(fmt_reg);
        end
        case (f)
            FMT_RGBA, FMT_ARGB, FMT_BGRA, FMT_ABGR: keeps_alpha = 1'b1;
            default: keeps_alpha = 1'b0;
        endcase
        // Formats without alpha flatten the pixel onto the background first.
        if (!keeps_alpha)
        begin
            r = blend_over_bg(r, bg_red_reg, a);
            g = blend_over_bg(g, bg_green_reg, a);
            b = blend_over_bg(b, bg_blue_reg, a);
        end
        p = '0;
        case (f)
            FMT_RGB:  {p.b0, p.b1, p.b2, p.b3} = {r, g, b, 8'h00};
            FMT_BGR:  {p.b0, p.b1, p.b2, p.b3} = {b, g, r, 8'h00};
            FMT_RGBA: {p.b0, p.b1, p.b2, p.b3} = {r, g, b, a};
            FMT_ARGB: {p.b0, p.b1, p.b2, p.b3} = {a, r, g, b};
            FMT_BGRA: {p.b0, p.b1, p.b2, p.b3} = {b, g, r, a};
            FMT_ABGR: {p.b0, p.b1, p.b2, p.b3} = {a, b, g, r};
            FMT_XRGB: {p.b0, p.b1, p.b2, p.b3} = {PadByte, r, g, b};
            FMT_RGBX: {p.b0, p.b1, p.b2, p.b3} = {r, g, b, PadByte};
            FMT_XBGR: {p.b0, p.b1, p.b2, p.b3} = {PadByte, b, g, r};
            default:  {p.b0, p.b1, p.b2, p.b3} = {b, g, r, PadByte};
        endcase
        p.cnt = (f == FMT_RGB || f == FMT_BGR) ? Count3 : Count4;
        p.last = last;
        p.opaque = last && (!keeps_alpha || (alpha_run_full && (a == FullAlpha)));
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: both channels are sampled at the rising edge, before any
    // nonblocking update of that edge lands, so a beat is seen exactly when
    // valid is high and stall is low.
    // ------------------------------------------------------------------

    task automatic check_field(input string field, input logic [PixW-1:0] want,
                               input logic [PixW-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field,
                     want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        packed_pixel_t want;
        if (rst_n)
        begin
            // The output beat is checked first; a pixel passes the input register and
            // the result register, so the output never holds the input beat of the same edge.
            if (out_valid && !out_stall)
            begin
                pixels_out++;
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t ns: output beat with no pixel outstanding, %s %h %h %h %h",
                             $time, "actual", out_byte0, out_byte1, out_byte2, out_byte3);
                    mismatches++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    check_field("out_byte0", want.b0, out_byte0);
                    check_field("out_byte1", want.b1, out_byte1);
                    check_field("out_byte2", want.b2, out_byte2);
                    check_field("out_byte3", want.b3, out_byte3);
                    check_field("byte_count", PixW'(want.cnt), PixW'(byte_count));
                    check_field("out_last", PixW'(want.last), PixW'(out_last));
                    check_field("image_opaque", PixW'(want.opaque), PixW'(image_opaque));
                end
            end
            if (in_valid && in_stall)
            begin
                held_off_cycles++;
            end
            if (in_valid && !in_stall)
            begin
                want = convert_pixel(in_red, in_green, in_blue, in_alpha, in_last);
                pending_pixels.push_back(want);
                pixels_in++;
                codes_seen[fmt_reg] = 1'b1;
                if (in_last)
                begin
                    image_ends++;
                    if (want.opaque)
                    begin
                        opaque_ends++;
                    end
                end
                // The run restarts after the last pixel of each image.
                alpha_run_full = in_last ? 1'b1
                                         : (alpha_run_full && (in_alpha == FullAlpha));
            end
        end
    end

    // Watchdog: any beat on either channel or any APB access counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("%0t ns: watchdog, no beat for %0d cycles, %0d pixels outstanding",
                         $time, idle_cycles, pending_pixels.size());
                $display("rgba_pixel_format_converter verification failed");
                $finish;
            end
        end
    end

    // Receiver: stalls at the current random rate, or holds the output off
    // completely while a forced hold-off is counting down.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // APB access. Setup cycle, then access cycle; the register takes the
    // write at the edge where psel, penable, pwrite and pready are all high.
    // ------------------------------------------------------------------

    task automatic apb_write(input reg_idx_t idx, input logic [PixW-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= ApbDataW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_OUT_FORMAT: fmt_reg = value[FmtW-1:0];
            REG_BG_RED:     bg_red_reg = value;
            REG_BG_GREEN:   bg_green_reg = value;
            default:        bg_blue_reg = value;
        endcase
    endtask

    task automatic apb_read_check(input reg_idx_t idx, input logic [PixW-1:0] want);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata !== ApbDataW'(want))
        begin
            $display("%0t ns: register %s read mismatch, expected %0d, actual %0d",
                     $time, idx.name(), want, prdata);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes every register and reads each one back.
    task automatic set_config(input logic [FmtW-1:0] fmt, input logic [PixW-1:0] bg_r,
                              input logic [PixW-1:0] bg_g, input logic [PixW-1:0] bg_b);
        apb_write(REG_OUT_FORMAT, PixW'(fmt));
        apb_write(REG_BG_RED, bg_r);
        apb_write(REG_BG_GREEN, bg_g);
        apb_write(REG_BG_BLUE, bg_b);
        apb_read_check(REG_OUT_FORMAT, PixW'(fmt_reg));
        apb_read_check(REG_BG_RED, bg_red_reg);
        apb_read_check(REG_BG_GREEN, bg_green_reg);
        apb_read_check(REG_BG_BLUE, bg_blue_reg);
    endtask

    // ------------------------------------------------------------------
    // Pixel stimulus
    // ------------------------------------------------------------------

    // Offers one pixel and returns at the edge where it is taken. in_valid is
    // left high so that back-to-back beats need no extra assignment; a gap,
    // when the sender idles, lowers it first. Each cycle before the beat is
    // idle with the sender's idle rate.
    task automatic send_pixel(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                              input logic [PixW-1:0] b, input logic [PixW-1:0] a,
                              input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_red <= r;
        in_green <= g;
        in_blue <= b;
        in_alpha <= a;
        in_last <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Stops offering and waits until every converted pixel has come out, plus
    // the pipeline depth so a spurious extra beat would still be caught.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LatencyCycles + 2) @(posedge clk);
    endtask

    function automatic logic [PixW-1:0] random_channel;
        if ($urandom_range(9) == 0)
        begin
            return $urandom_range(1) ? FullAlpha : '0;
        end
        return PixW'($urandom);
    endfunction

    // One pixel of a random image. Solid images are mostly full alpha with a
    // rare break; the others mix full, zero and arbitrary alpha.
    task automatic send_random_pixel;
        logic [PixW-1:0] a;
        logic            last;
        if (solid_image)
        begin
            a = ($urandom_range(19) == 0) ? PixW'($urandom) : FullAlpha;
        end
        else
        begin
            case ($urandom_range(9))
                0, 1, 2: a = FullAlpha;
                3:       a = '0;
                default: a = PixW'($urandom);
            endcase
        end
        last = ($urandom_range(11) == 0);
        send_pixel(random_channel(), random_channel(), random_channel(), a, last);
        if (last)
        begin
            solid_image = 1'($urandom_range(1));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers come out of reset with RGBA and a black background.
    task automatic test_reset_values;
        apb_read_check(REG_OUT_FORMAT, PixW'(FmtReset));
        apb_read_check(REG_BG_RED, '0);
        apb_read_check(REG_BG_GREEN, '0);
        apb_read_check(REG_BG_BLUE, '0);
    endtask

    task automatic test_directed_formats;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // Reset format: an image broken by a transparent pixel, then a fully
        // opaque one-pixel image right after it.
        send_pixel('0, '0, '0, '0, 1'b0);
        send_pixel(FullAlpha, FullAlpha, FullAlpha, FullAlpha, 1'b1);
        send_pixel(FullAlpha, FullAlpha, FullAlpha, FullAlpha, 1'b1);
        drain();
        // Every defined format once, with white and black backgrounds in turn
        // and alpha climbing from fully transparent.
        for (int i = FMT_RGB; i <= FMT_BGRX; i++)
        begin
            if (i % 2 == 0)
            begin
                set_config(FmtW'(i), FullAlpha, FullAlpha, FullAlpha);
            end
            else
            begin
                set_config(FmtW'(i), '0, '0, '0);
            end
            send_pixel(FullAlpha, '0, 8'h5a, PixW'(i * 28), i == FMT_BGRX);
            drain();
        end
        // A code with no format of its own passes the pixel through as RGBA.
        set_config(FmtCodeTop, 8'h01, 8'h02, 8'h03);
        send_pixel(8'd10, 8'd20, 8'd30, 8'd17, 1'b1);
        drain();
        // Opaque image in an alpha format.
        set_config(FMT_ABGR, 8'h80, 8'h40, 8'h20);
        send_pixel(8'h12, 8'h34, 8'h56, FullAlpha, 1'b0);
        send_pixel(8'h9a, 8'hbc, 8'hde, FullAlpha, 1'b1);
        drain();
        // Format switched mid-image: the translucent first pixel does not matter
        // because the last pixel lands in a format without alpha.
        set_config(FMT_ARGB, '0, '0, '0);
        send_pixel(8'h01, 8'h02, 8'h03, 8'd10, 1'b0);
        drain();
        set_config(FMT_RGB, 8'h7f, 8'h80, 8'hff);
        send_pixel(8'd200, 8'd100, 8'd50, FullAlpha, 1'b1);
        drain();
    endtask

    // Random images in chunks; each chunk runs under a fresh register setting,
    // a quarter of them at the extremes of the background.
    task automatic test_random_images(input int tx_pct, input int rx_pct, input int items);
        int              sent;
        int              chunk;
        logic [FmtW-1:0] fmt;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(4) == 0)
            begin
                fmt = FmtW'($urandom_range(FmtCodeTop, FMT_BGRX + 1));
            end
            else
            begin
                fmt = FmtW'($urandom_range(FMT_BGRX, FMT_RGB));
            end
            if ($urandom_range(3) == 0)
            begin
                set_config(fmt, $urandom_range(1) ? FullAlpha : '0,
                           $urandom_range(1) ? FullAlpha : '0,
                           $urandom_range(1) ? FullAlpha : '0);
            end
            else
            begin
                set_config(fmt, PixW'($urandom), PixW'($urandom), PixW'($urandom));
            end
            chunk = $urandom_range(20, 60);
            repeat (chunk) send_random_pixel();
            sent += chunk;
            drain();
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so both pipeline stages fill and in_stall must rise.
    task automatic test_backpressure;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(FMT_BGRA, PixW'($urandom), PixW'($urandom), PixW'($urandom));
        hold_left = HoldCycles;
        repeat (PressureItems) send_random_pixel();
        drain();
        set_config(FMT_XRGB, PixW'($urandom), PixW'($urandom), PixW'($urandom));
        hold_left = HoldCycles;
        repeat (PressureItems) send_random_pixel();
        drain();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        in_red <= '0;
        in_green <= '0;
        in_blue <= '0;
        in_alpha <= '0;
        in_last <= 1'b0;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_directed_formats();
        // Slow sender against a mostly stalled receiver, then the reverse,
        // then both sides at full rate.
        test_random_images(33, 88, RandomItems / 3);
        test_random_images(88, 33, RandomItems / 3);
        test_random_images(0, 0, RandomItems / 3);
        test_backpressure();

        drain();
        $display("Covered %0d pixels in, %0d out, %0d image ends (%0d reported opaque).",
                 pixels_in, pixels_out, image_ends, opaque_ends);
        $display("Used %0d of 16 format codes; input held off on %0d cycles.",
                 $countones(codes_seen), held_off_cycles);
        if (mismatches == 0 && pending_pixels.size() == 0)
        begin
            $display("rgba_pixel_format_converter verification clean");
        end
        else
        begin
            $display("rgba_pixel_format_converter verification failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/rpfc_pkg.sv
design/rpfc_blend.sv
design/rgba_pixel_format_converter.sv
verif/rgba_pixel_format_converter_tb.sv
